FILE: rtl/assert_macros.svh
// Assertion macros used by the sampler back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/tws_pkg.sv
`default_nettype none
package tws_pkg;
    localparam int CoordW = 24;
    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_CLAMP  = 2'd1;
    localparam logic [2:0] REG_WRAP   = 3'd0;
    localparam logic [2:0] REG_FILTER = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SINGLE = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [23:0] coord_u;
        logic [23:0] coord_v;
        logic [7:0]  texel_col;
        logic [7:0]  texel_row;
        logic [7:0]  texel_red;
        logic [7:0]  texel_green;
        logic [7:0]  texel_blue;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } out_item_t;

    typedef struct packed {
        logic [1:0] wrap_mode;
        logic       filter_mode;
        logic [8:0] tex_width;
        logic [8:0] tex_height;
        logic       single_channel;
    } cfg_t;
endpackage
`default_nettype wire

FILE: rtl/tws_front.sv
`default_nettype none
// Front: wraps and scales coordinates, yields integer texel positions and weights.
module tws_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tws_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tws_pkg::in_item_t in_item,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output logic [2*XW+2*YW+2*FRAC_BITS+1:0] q_data,
    output logic [23:0]            q_texel
);
    import tws_pkg::*;
    localparam int SW = CoordW;
    localparam int PW = FRAC_BITS + 1 + 13;
    localparam int QW = 2*XW + 2*YW + 2*FRAC_BITS + 2;

    // stage 1: wrap
    logic                 s1_valid_reg;
    logic [FRAC_BITS:0]   s1_u_reg, s1_v_reg;
    logic                 s1_near_reg;
    logic [12:0]          s1_wm1_reg, s1_hm1_reg;
    logic                 s1_wr_reg;
    logic [XW-1:0]        s1_wx_reg;
    logic [YW-1:0]        s1_wy_reg;
    logic [23:0]          s1_wd_reg;
    // stage 2: scaled product
    logic                 s2_valid_reg;
    logic [PW-1:0]        s2_s_reg, s2_t_reg;
    logic                 s2_near_reg;
    logic                 s2_wr_reg;
    logic [XW-1:0]        s2_wx_reg;
    logic [YW-1:0]        s2_wy_reg;
    logic [23:0]          s2_wd_reg;

    logic adv1, adv2, adv_out;
    logic [QW-1:0] q_data_reg;
    logic [23:0] q_texel_reg;
    logic q_valid_reg;
    logic wr_in_range;

    function automatic logic [FRAC_BITS:0] wrap_fn(input logic [SW-1:0] c, input logic [1:0] wm);
        logic signed [SW:0] cs, one;
        cs  = {c[SW-1], c};
        one = (SW+1)'(1) <<< FRAC_BITS;
        if (wm == WRAP_REPEAT)
            wrap_fn = {1'b0, c[FRAC_BITS-1:0]};
        else if (wm == WRAP_CLAMP) begin
            if (cs < 0) wrap_fn = '0;
            else if (cs > one) wrap_fn = (FRAC_BITS+1)'(1) << FRAC_BITS;
            else wrap_fn = cs[FRAC_BITS:0];
        end else begin
            if (cs < 0 || cs > one) wrap_fn = '0;
            else wrap_fn = cs[FRAC_BITS:0];
        end
    endfunction

    function automatic logic [12:0] dim_fn(input logic [8:0] r, input int mx);
        if (r == 9'd0) dim_fn = 13'd0;
        else if (int'(r) > mx) dim_fn = 13'(mx - 1);
        else dim_fn = 13'(r) - 13'd1;
    endfunction

    assign adv_out = !q_valid_reg || q_ready;
    assign adv2    = !s2_valid_reg || adv_out;
    assign adv1    = !s1_valid_reg || adv2;
    // writes travel with samples so the store changes in item order; out-of-range writes drop here
    assign in_ready = adv1;
    assign wr_in_range = int'(in_item.texel_col) < MAX_WIDTH
                      && int'(in_item.texel_row) < MAX_HEIGHT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= in_valid && (in_item.mode || wr_in_range);
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv_out) q_valid_reg <= s2_valid_reg;
        end
        if (adv1) begin
            s1_u_reg    <= wrap_fn(in_item.coord_u, cfg.wrap_mode);
            s1_v_reg    <= wrap_fn(in_item.coord_v, cfg.wrap_mode);
            s1_near_reg <= !cfg.filter_mode;
            s1_wm1_reg  <= dim_fn(cfg.tex_width, MAX_WIDTH);
            s1_hm1_reg  <= dim_fn(cfg.tex_height, MAX_HEIGHT);
            s1_wr_reg   <= !in_item.mode;
            s1_wx_reg   <= XW'(in_item.texel_col);
            s1_wy_reg   <= YW'(in_item.texel_row);
            s1_wd_reg   <= cfg.single_channel
                         ? {3{in_item.texel_red}}
                         : {in_item.texel_red, in_item.texel_green, in_item.texel_blue};
        end
        if (adv2) begin
            s2_s_reg    <= PW'(s1_u_reg) * PW'(s1_wm1_reg);
            s2_t_reg    <= PW'(s1_v_reg) * PW'(s1_hm1_reg);
            s2_near_reg <= s1_near_reg;
            s2_wr_reg   <= s1_wr_reg;
            s2_wx_reg   <= s1_wx_reg;
            s2_wy_reg   <= s1_wy_reg;
            s2_wd_reg   <= s1_wd_reg;
        end
        if (adv_out) begin
            q_data_reg  <= s2_wr_reg
                         ? {1'b1, 1'b0, s2_wx_reg, s2_wx_reg, s2_wy_reg, s2_wy_reg,
                            {(2*FRAC_BITS){1'b0}}}
                         : pack_fn(s2_s_reg, s2_t_reg, s2_near_reg);
            q_texel_reg <= s2_wd_reg;
        end
    end

    function automatic logic [QW-1:0] pack_fn(input logic [PW-1:0] s, input logic [PW-1:0] t,
                                              input logic nr);
        logic [PW-1:0] sh, th;
        logic [XW-1:0] x0, x1;
        logic [YW-1:0] y0, y1;
        logic [FRAC_BITS-1:0] a, b;
        sh = s + (PW'(1) << (FRAC_BITS-1));
        th = t + (PW'(1) << (FRAC_BITS-1));
        if (nr) begin
            x0 = XW'(sh >> FRAC_BITS);
            y0 = YW'(th >> FRAC_BITS);
            a = '0;
            b = '0;
        end else begin
            x0 = XW'(s >> FRAC_BITS);
            y0 = YW'(t >> FRAC_BITS);
            a = s[FRAC_BITS-1:0];
            b = t[FRAC_BITS-1:0];
        end
        x1 = x0 + XW'(a != '0);
        y1 = y0 + YW'(b != '0);
        pack_fn = {1'b0, nr, x0, x1, y0, y1, a, b};
    endfunction

    assign q_valid = q_valid_reg;
    assign q_data  = q_data_reg;
    assign q_texel = q_texel_reg;
endmodule
`default_nettype wire

FILE: rtl/tws_back.sv
`default_nettype none
`include "assert_macros.svh"
// Back: fetches four texels from parity banks and blends them.
module tws_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire logic [2*XW+2*YW+2*FRAC_BITS+1:0] q_data,
    input  wire logic [23:0]        q_texel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tws_pkg::out_item_t      m_item
);
    import tws_pkg::*;
    localparam int BD = (MAX_WIDTH/2 + 1) * (MAX_HEIGHT/2 + 1);
    localparam int BA = $clog2(BD);
    localparam int HX = MAX_WIDTH/2 + 1;
    localparam int WW = FRAC_BITS + 9;

    logic [23:0] bank0 [BD];
    logic [23:0] bank1 [BD];
    logic [23:0] bank2 [BD];
    logic [23:0] bank3 [BD];

    logic       wr, nr;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [FRAC_BITS-1:0] a, b;
    assign {wr, nr, x0, x1, y0, y1, a, b} = q_data;

    function automatic logic [BA-1:0] addr_fn(input logic [XW-1:0] x, input logic [YW-1:0] y);
        addr_fn = BA'(int'(y >> 1) * HX + int'(x >> 1));
    endfunction

    // each bank holds one parity class (x[0], y[0]); the four neighbors hit distinct banks
    logic [XW-1:0] ex, ox;
    logic [YW-1:0] ey, oy;
    always_comb begin
        ex = x0[0] ? x1 : x0;
        ox = x0[0] ? x0 : x1;
        ey = y0[0] ? y1 : y0;
        oy = y0[0] ? y0 : y1;
    end

    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;
    logic [23:0] d00_reg, d01_reg, d10_reg, d11_reg;
    logic        sx_reg, sy_reg, nr1_reg, nr2_reg;
    logic [FRAC_BITS-1:0] a1_reg, b1_reg, b2_reg;
    logic [3*WW-1:0] top_reg, bot_reg;
    out_item_t res_reg;

    assign adv3 = !v3_reg || m_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign q_ready = adv1;

    // a write item carries its column in x0, its row in y0
    always_ff @(posedge aclk) begin
        if (q_valid && adv1 && wr) begin
            unique case ({y0[0], x0[0]})
                2'b00: bank0[addr_fn(x0, y0)] <= q_texel;
                2'b01: bank1[addr_fn(x0, y0)] <= q_texel;
                2'b10: bank2[addr_fn(x0, y0)] <= q_texel;
                default: bank3[addr_fn(x0, y0)] <= q_texel;
            endcase
        end
        if (adv1) begin
            d00_reg <= bank0[addr_fn(ex, ey)];
            d01_reg <= bank1[addr_fn(ox, ey)];
            d10_reg <= bank2[addr_fn(ex, oy)];
            d11_reg <= bank3[addr_fn(ox, oy)];
            sx_reg  <= x0[0];
            sy_reg  <= y0[0];
            nr1_reg <= nr;
            a1_reg  <= a;
            b1_reg  <= b;
        end
    end

    // a zero weight drops the second neighbor entirely
    function automatic logic [WW-1:0] lerp(input logic [7:0] p, input logic [7:0] q,
                                          input logic [FRAC_BITS-1:0] w);
        logic [FRAC_BITS:0] iw;
        iw = (FRAC_BITS+1)'(1) << FRAC_BITS;
        iw = iw - (FRAC_BITS+1)'(w);
        lerp = WW'(iw) * WW'(p) + ((w != '0) ? WW'(w) * WW'(q) : WW'(0));
    endfunction

    function automatic logic [15:0] lerp2(input logic [WW-1:0] p, input logic [WW-1:0] q,
                                          input logic [FRAC_BITS-1:0] w);
        logic [FRAC_BITS:0] iw;
        logic [WW+FRAC_BITS:0] s;
        iw = (FRAC_BITS+1)'(1) << FRAC_BITS;
        iw = iw - (FRAC_BITS+1)'(w);
        s = (WW+FRAC_BITS+1)'(iw) * (WW+FRAC_BITS+1)'(p)
          + ((w != '0) ? (WW+FRAC_BITS+1)'(w) * (WW+FRAC_BITS+1)'(q)
                       : (WW+FRAC_BITS+1)'(0));
        lerp2 = 16'(s >> (2*FRAC_BITS - 8));
    endfunction

    logic [23:0] p1, p2, p3, p4;
    always_comb begin
        p1 = sy_reg ? (sx_reg ? d11_reg : d10_reg) : (sx_reg ? d01_reg : d00_reg);
        p2 = sy_reg ? (sx_reg ? d10_reg : d11_reg) : (sx_reg ? d00_reg : d01_reg);
        p3 = sy_reg ? (sx_reg ? d01_reg : d00_reg) : (sx_reg ? d11_reg : d10_reg);
        p4 = sy_reg ? (sx_reg ? d00_reg : d01_reg) : (sx_reg ? d10_reg : d11_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= q_valid && !wr;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
        if (adv2) begin
            for (int k = 0; k < 3; k++) begin
                top_reg[k*WW +: WW] <= lerp(p1[16-8*k +: 8], p2[16-8*k +: 8], a1_reg);
                bot_reg[k*WW +: WW] <= lerp(p3[16-8*k +: 8], p4[16-8*k +: 8], a1_reg);
            end
            b2_reg  <= b1_reg;
            nr2_reg <= nr1_reg;
        end
        if (adv3) begin
            res_reg.out_red   <= lerp2(top_reg[0 +: WW], bot_reg[0 +: WW], b2_reg);
            res_reg.out_green <= lerp2(top_reg[WW +: WW], bot_reg[WW +: WW], b2_reg);
            res_reg.out_blue  <= lerp2(top_reg[2*WW +: WW], bot_reg[2*WW +: WW], b2_reg);
        end
    end

    assign m_valid = v3_reg;
    assign m_item  = res_reg;

    `ASSERT_NEXT(a_hold_out, aclk, aresetn, v3_reg && !m_ready, v3_reg && $stable(res_reg), "result changed while stalled")
    `ASSERT_NEXT(a_stage_fill, aclk, aresetn, v2_reg && adv3, v3_reg, "stage lost an item")
    `ASSERT_IMPL(a_near_w, aclk, aresetn, !(v2_reg && nr2_reg) || b2_reg == '0, "nearest item has weight")
endmodule
`default_nettype wire

FILE: rtl/texture_wrap_bilinear_sampler_core.sv
`default_nettype none
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    tws_pkg::in_item_t s_item
// m_       out  m_valid/m_ready    tws_pkg::out_item_t m_item
// cfg      in   cfg_we             cfg_index, cfg_data
// One item per cycle sustained while m_ready stays high; a sample passes 3 front stages (wrap,
// scale multiply, split) and 3 back stages (bank read, row blend, column blend) before m_valid.
// Texel writes follow samples down the pipe and update one parity bank as they enter the back.
// Reset (aresetn low, synchronous) clears the config registers and pipeline valids; the texel
// store is not cleared. Stalls on m_ready propagate back through the queue to s_ready.
module texture_wrap_bilinear_sampler_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tws_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tws_pkg::out_item_t      m_item
);
    import tws_pkg::*;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int QW = 2*XW + 2*YW + 2*FRAC_BITS + 2;

    cfg_t cfg_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_mode      <= 2'd0;
            cfg_reg.filter_mode    <= 1'b0;
            cfg_reg.tex_width      <= 9'd256;
            cfg_reg.tex_height     <= 9'd256;
            cfg_reg.single_channel <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WRAP:   cfg_reg.wrap_mode      <= cfg_data[1:0];
                REG_FILTER: cfg_reg.filter_mode    <= cfg_data[0];
                REG_WIDTH:  cfg_reg.tex_width      <= cfg_data;
                REG_HEIGHT: cfg_reg.tex_height     <= cfg_data;
                REG_SINGLE: cfg_reg.single_channel <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic front_ready, q_valid, q_ready;
    logic [QW-1:0] q_data;
    logic [23:0] q_texel;

    assign s_ready = front_ready;

    tws_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(s_valid), .in_ready(front_ready), .in_item(s_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data), .q_texel(q_texel)
    );

    tws_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data), .q_texel(q_texel),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );
endmodule
`default_nettype wire

FILE: sim/texture_wrap_bilinear_sampler_core_tb.sv
`default_nettype none
module texture_wrap_bilinear_sampler_core_tb;
    import tws_pkg::*;

    localparam int  FRAC    = 16;
    localparam int  DIM_MAX = 256;
    localparam int  REGION  = 16;
    localparam int  LATENCY = 12;
    localparam longint ONE  = 64'sd1 << FRAC;
    localparam int  LIMIT   = 3000000;
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;
    localparam logic [1:0] WRAP_ZERO = 2'd2;
    localparam logic [1:0] WRAP_SEL3 = 2'd3;
    localparam logic FILT_NEAREST  = 1'b0;
    localparam logic FILT_BILINEAR = 1'b1;

    class texel_scoreboard;
        logic [23:0] texels[DIM_MAX*DIM_MAX];
        cfg_t        cfg;
        out_item_t   pending_q[$];
        int          errors;
        int          n_samples;
        int          n_writes;

        function new();
            cfg = '{wrap_mode: WRAP_REPEAT, filter_mode: FILT_NEAREST,
                    tex_width: 9'd256, tex_height: 9'd256, single_channel: 1'b0};
            errors = 0;
            n_samples = 0;
            n_writes = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [8:0] d);
            case (idx)
                REG_WRAP:   cfg.wrap_mode = d[1:0];
                REG_FILTER: cfg.filter_mode = d[0];
                REG_WIDTH:  cfg.tex_width = d;
                REG_HEIGHT: cfg.tex_height = d;
                REG_SINGLE: cfg.single_channel = d[0];
                default: ;
            endcase
        endfunction

        function longint wrap(logic [23:0] raw);
            longint c;
            c = longint'($signed(raw));
            if (cfg.wrap_mode == WRAP_REPEAT) return c & (ONE - 1);
            if (cfg.wrap_mode == WRAP_CLAMP) begin
                if (c < 0) return 0;
                if (c > ONE) return ONE;
                return c;
            end
            if (c < 0 || c > ONE) return 0;
            return c;
        endfunction

        function longint dim_m1(logic [8:0] r);
            if (r == 0) return 0;
            if (r > DIM_MAX) return DIM_MAX - 1;
            return longint'(r) - 1;
        endfunction

        function longint chan(longint x, longint y, int k);
            logic [23:0] t;
            t = texels[y*DIM_MAX + x];
            return longint'(t[16-8*k +: 8]);
        endfunction

        function out_item_t sample(in_item_t it);
            longint s, t, x0, y0, a, b, x1, y1, top, bot, sum;
            logic [15:0] ch[3];
            s = wrap(it.coord_u) * dim_m1(cfg.tex_width);
            t = wrap(it.coord_v) * dim_m1(cfg.tex_height);
            for (int k = 0; k < 3; k++) begin
                if (cfg.filter_mode == FILT_NEAREST) begin
                    ch[k] = 16'(chan((s + ONE/2) >> FRAC, (t + ONE/2) >> FRAC, k) << 8);
                end else begin
                    x0 = s >> FRAC;
                    y0 = t >> FRAC;
                    a = s & (ONE - 1);
                    b = t & (ONE - 1);
                    x1 = x0 + (a != 0);
                    y1 = y0 + (b != 0);
                    top = (ONE - a) * chan(x0, y0, k) + a * chan(x1, y0, k);
                    bot = (ONE - a) * chan(x0, y1, k) + a * chan(x1, y1, k);
                    sum = (ONE - b) * top + b * bot;
                    ch[k] = 16'(sum >> (2*FRAC - 8));
                end
            end
            return '{out_red: ch[0], out_green: ch[1], out_blue: ch[2]};
        endfunction

        function void note_input(in_item_t it);
            logic [7:0] g, bl;
            if (it.mode == MODE_WRITE) begin
                g  = cfg.single_channel ? it.texel_red : it.texel_green;
                bl = cfg.single_channel ? it.texel_red : it.texel_blue;
                texels[int'(it.texel_row)*DIM_MAX + int'(it.texel_col)] = {it.texel_red, g, bl};
                n_writes++;
            end else begin
                pending_q.push_back(sample(it));
                n_samples++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.out_red !== want.out_red) begin
                $display("%0t: red exp %h got %h", $time, want.out_red, got.out_red);
                errors++;
            end
            if (got.out_green !== want.out_green) begin
                $display("%0t: green exp %h got %h", $time, want.out_green, got.out_green);
                errors++;
            end
            if (got.out_blue !== want.out_blue) begin
                $display("%0t: blue exp %h got %h", $time, want.out_blue, got.out_blue);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [8:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;

    texel_scoreboard sb;
    bit  quiet;
    int  cycles;
    int  n_configs;

    texture_wrap_bilinear_sampler_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk)
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);

    // handshakes are stable from the falling edge to the next rising edge
    always @(negedge aclk)
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);

    // one idle cycle before about 30% of items keeps the sender idle ~23% of the time
    task automatic send(in_item_t it);
        if (!quiet && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
            @(posedge aclk);
        end
        sb.note_input(it);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic configure(logic [1:0] wm, logic fm, logic [8:0] w, logic [8:0] h, logic sc);
        logic [8:0] vals[5];
        vals = '{9'(wm), 9'(fm), w, h, 9'(sc)};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            sb.set_reg(3'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        n_configs++;
    endtask

    function automatic in_item_t rand_item();
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom});
        return it;
    endfunction

    task automatic write_texel(int col, int row, logic [23:0] rgb);
        in_item_t it;
        it = rand_item();
        it.mode = MODE_WRITE;
        it.texel_col = 8'(col);
        it.texel_row = 8'(row);
        {it.texel_red, it.texel_green, it.texel_blue} = rgb;
        send(it);
    endtask

    task automatic sample_at(longint u, longint v);
        in_item_t it;
        it = rand_item();
        it.mode = MODE_SAMPLE;
        it.coord_u = 24'(u);
        it.coord_v = 24'(v);
        send(it);
    endtask

    function automatic longint rand_coord();
        case ($urandom_range(3))
            0: return longint'($signed(24'($urandom)));
            1: return longint'($urandom_range(0, 2*ONE)) - ONE/2;
            2: return longint'($urandom_range(0, 3)) * ONE - 1 + $urandom_range(0, 2);
            default: return longint'($urandom_range(0, ONE));
        endcase
    endfunction

    // sizes stay within the prefilled corner so every reachable texel holds a value
    function automatic logic [8:0] rand_dim();
        case ($urandom_range(4))
            0: return 9'd1;
            1: return 9'(REGION);
            2: return 9'($urandom_range(0, REGION));
            default: return 9'($urandom_range(2, REGION));
        endcase
    endfunction

    initial begin
        in_item_t it;
        aclk = 0;
        aresetn = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 0;
        s_item = '0;
        m_ready = 0;
        quiet = 0;
        cycles = 0;
        n_configs = 0;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every texel in the corner gets a value before any sample can reach it
        for (int r = 0; r < REGION; r++)
            for (int c = 0; c < REGION; c++)
                write_texel(c, r, 24'($urandom));
        drain();

        // selector 3 acts like zero mode; size 0 counts as 1, oversize saturates
        configure(WRAP_SEL3, FILT_BILINEAR, 9'd0, 9'd511, 1'b1);
        write_texel(0, 0, 24'hA5_3C_0F);
        write_texel(255, 255, 24'hFF_00_FF);
        sample_at(-(ONE*128), ONE*128 - 1);
        sample_at(0, ONE + 1);
        drain();
        // full size, clamped to the corners of the store
        configure(WRAP_CLAMP, FILT_NEAREST, 9'd256, 9'd256, 1'b0);
        write_texel(255, 0, 24'h00_FF_00);
        sample_at(ONE, -1);
        sample_at(0, -5);
        sample_at(ONE*128 - 1, -(ONE*128));
        sample_at(ONE + 5, ONE);
        drain();
        configure(WRAP_CLAMP, FILT_NEAREST, 9'(REGION), 9'(REGION), 1'b0);
        sample_at(ONE/2, ONE/2 - 1);
        sample_at(ONE, ONE);
        drain();
        configure(WRAP_ZERO, FILT_BILINEAR, 9'(REGION), 9'(REGION), 1'b0);
        sample_at(ONE + 1, ONE);
        sample_at(24'h012345, -(ONE/2));
        sample_at(ONE, ONE);
        sample_at(ONE/3, 2*ONE/3);
        drain();
        configure(WRAP_REPEAT, FILT_BILINEAR, 9'd2, 9'd1, 1'b0);
        sample_at(-(ONE + ONE/2), 3*ONE + 7);
        sample_at(ONE - 1, -1);
        sample_at(0, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph == 4);
            if (ph == 9)
                configure(WRAP_CLAMP, FILT_BILINEAR, 9'(REGION), 9'(REGION), 1'b0);
            else
                configure(2'($urandom_range(3)), 1'($urandom), rand_dim(), rand_dim(),
                          1'($urandom));
            for (int n = 0; n < 110; n++) begin
                it = rand_item();
                it.mode = ($urandom_range(99) < 25) ? MODE_WRITE : MODE_SAMPLE;
                if (it.mode == MODE_SAMPLE && $urandom_range(3) != 0) begin
                    it.coord_u = 24'(rand_coord());
                    it.coord_v = 24'(rand_coord());
                end
                send(it);
            end
            drain();
        end
        quiet = 0;

        $display("Covered %0d samples and %0d texel writes over %0d register settings,",
                 sb.n_samples, sb.n_writes, n_configs);
        $display("all wrap selectors, both filters, sizes from 0 up to 511.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
